[sv/crh_pkg.sv]
// ----------------------------------------------------------------------------
// crh_pkg
// Shared types and constants of the range header parser: value width,
// parse phases, result status codes and the characters the parser looks for.
// ----------------------------------------------------------------------------
package crh_pkg;

   localparam int VALUE_BITS = 63;
   localparam int POS_W      = 63;
   localparam int PROD_W     = VALUE_BITS + 4;

   typedef enum logic [7:0] {
      PH_LEAD  = 8'b0000_0001,
      PH_UNIT  = 8'b0000_0010,
      PH_SEP   = 8'b0000_0100,
      PH_GAP   = 8'b0000_1000,
      PH_FIRST = 8'b0001_0000,
      PH_LAST  = 8'b0010_0000,
      PH_TOTAL = 8'b0100_0000,
      PH_TRAIL = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_OK                = 2'd0,
      STATUS_MALFORMED         = 2'd1,
      STATUS_LAST_BEFORE_FIRST = 2'd2,
      STATUS_LAST_NOT_BELOW    = 2'd3
   } status_type;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   localparam logic [2:0] UNIT_LEN  = 3'd5;
   localparam logic [2:0] UNIT_LAST = 3'd4;

   // lower-case letters of the unit word "bytes"
   function automatic logic [7:0] unit_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h62;
         3'd1: ch = 8'h79;
         3'd2: ch = 8'h74;
         3'd3: ch = 8'h65;
         3'd4: ch = 8'h73;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[sv/crh_req_if.sv]
// ----------------------------------------------------------------------------
// crh_req_if
// Request channel: one header character per transaction, last one marked.
// ----------------------------------------------------------------------------
interface crh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

[sv/crh_rsp_if.sv]
// ----------------------------------------------------------------------------
// crh_rsp_if
// Response channel: parse status and the three positions of one header value.
// ----------------------------------------------------------------------------
interface crh_rsp_if;
   import crh_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   logic [POS_W-1:0] first_pos;
   logic [POS_W-1:0] last_pos;
   logic [POS_W-1:0] total_length;
   logic             total_known;

   modport source (output valid, output status, output first_pos, output last_pos,
                   output total_length, output total_known, input ready);
   modport sink   (input valid, input status, input first_pos, input last_pos,
                   input total_length, input total_known, output ready);
endinterface

[sv/content_range_header_parser.sv]
// ----------------------------------------------------------------------------
// content_range_header_parser
// Streaming parser for a "bytes first-last/total" range header value.
// ----------------------------------------------------------------------------
// Takes one character per clock cycle unless the last character of a value is
// held waiting for a free capture register. The response for a value passes
// from the input register through the parse stage and the compare stage to
// the response register on the response port. Every
// stage has its own valid bit and only the stage that holds a finished value
// waits for the response side, so characters of the next value keep flowing
// while a response is pending. The cycle time is set by the shared
// multiply-by-ten accumulate with its overflow test in the parse stage, and by
// the two position compares in the compare stage.
module content_range_header_parser (
   input  logic       clock,
   input  logic       reset,
   crh_req_if.sink    req_ch,
   crh_rsp_if.source  rsp_ch
);
   import crh_pkg::*;

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_data_ff;
   logic        in_final_ff;

   // parse state
   phase_type             phase_ff, phase_in, phase_nx;
   logic [2:0]            unit_idx_ff, unit_idx_in, unit_idx_nx;
   logic [VALUE_BITS-1:0] first_acc_ff, first_acc_in, first_acc_nx;
   logic [VALUE_BITS-1:0] last_acc_ff, last_acc_in, last_acc_nx;
   logic [VALUE_BITS-1:0] total_acc_ff, total_acc_in, total_acc_nx;
   logic                  digits_ff, digits_in, digits_nx;
   logic                  star_ff, star_in, star_nx;
   logic                  error_ff, error_in, error_nx;

   // finished value awaiting compare
   logic                  cap_valid_ff;
   logic                  cap_ok_ff, cap_ok_in;
   logic [VALUE_BITS-1:0] cap_first_ff;
   logic [VALUE_BITS-1:0] cap_last_ff;
   logic [VALUE_BITS-1:0] cap_total_ff;
   logic                  cap_star_ff;

   // response register
   logic             rsp_valid_ff;
   status_type       rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0] rsp_first_ff, rsp_first_in;
   logic [POS_W-1:0] rsp_last_ff, rsp_last_in;
   logic [POS_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_known_ff, rsp_known_in;

   logic out_ready, cap_ready, in_go, fin_go;

   logic                  is_dig, is_blank, is_trail, unit_hit, do_acc, acc_ovf;
   logic [3:0]            dig_val;
   logic [7:0]            lc;
   logic [VALUE_BITS-1:0] acc_sel, acc_new;
   logic [PROD_W-1:0]     acc_ext, prod;

   logic last_lt_first, last_ge_total;

   // ---------------------------------------------------------------- handshake
   assign out_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign cap_ready    = !cap_valid_ff || out_ready;
   assign in_go        = in_valid_ff && (!in_final_ff || cap_ready);
   assign fin_go       = in_go && in_final_ff;
   assign req_ch.ready = !in_valid_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_data_ff  <= req_ch.data_byte;
         in_final_ff <= req_ch.final_byte;
      end
   end

   // ---------------------------------------------------------------- parse
   always_comb begin
      is_dig   = (in_data_ff >= CH_ZERO) && (in_data_ff <= CH_NINE);
      dig_val  = is_dig ? in_data_ff[3:0] : 4'd0;
      is_blank = in_data_ff inside {CH_SPACE, CH_TAB};
      is_trail = in_data_ff inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
      lc       = (in_data_ff inside {[CH_UP_A:CH_UP_Z]}) ? in_data_ff + CASE_GAP
                                                         : in_data_ff;
      unit_hit = (unit_idx_ff < UNIT_LEN) && (lc == unit_char(unit_idx_ff));

      case (phase_ff)
         PH_LAST:  acc_sel = last_acc_ff;
         PH_TOTAL: acc_sel = total_acc_ff;
         default:  acc_sel = first_acc_ff;
      endcase
      acc_ext = PROD_W'(acc_sel);
      prod    = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(dig_val);
      acc_ovf = |prod[PROD_W-1:VALUE_BITS];
      acc_new = prod[VALUE_BITS-1:0];
   end

   always_comb begin
      phase_nx     = phase_ff;
      unit_idx_nx  = unit_idx_ff;
      first_acc_nx = first_acc_ff;
      last_acc_nx  = last_acc_ff;
      total_acc_nx = total_acc_ff;
      digits_nx    = digits_ff;
      star_nx      = star_ff;
      error_nx     = error_ff;
      do_acc       = 1'b0;

      if (in_go && !error_ff) begin
         case (phase_ff)
            PH_LEAD, PH_UNIT: begin
               if (phase_ff == PH_LEAD && is_blank) begin
                  phase_nx = phase_ff;
               end else if (unit_hit) begin
                  unit_idx_nx = unit_idx_ff + 3'd1;
                  phase_nx    = (unit_idx_ff == UNIT_LAST) ? PH_SEP : PH_UNIT;
               end else begin
                  error_nx = 1'b1;
               end
            end
            PH_SEP: begin
               if (is_blank) phase_nx = PH_GAP;
               else          error_nx = 1'b1;
            end
            PH_GAP: begin
               if (is_dig) begin
                  phase_nx = PH_FIRST;
                  do_acc   = 1'b1;
               end else if (!is_blank) begin
                  error_nx = 1'b1;
               end
            end
            PH_FIRST: begin
               if (is_dig) begin
                  do_acc = 1'b1;
               end else if (in_data_ff == CH_DASH && digits_ff) begin
                  phase_nx  = PH_LAST;
                  digits_nx = 1'b0;
               end else begin
                  error_nx = 1'b1;
               end
            end
            PH_LAST: begin
               if (is_dig) begin
                  do_acc = 1'b1;
               end else if (in_data_ff == CH_SLASH && digits_ff) begin
                  phase_nx  = PH_TOTAL;
                  digits_nx = 1'b0;
               end else begin
                  error_nx = 1'b1;
               end
            end
            PH_TOTAL: begin
               if (is_dig && !star_ff) begin
                  do_acc = 1'b1;
               end else if (in_data_ff == CH_STAR && !digits_ff && !star_ff) begin
                  star_nx = 1'b1;
               end else if (is_trail && (digits_ff || star_ff)) begin
                  phase_nx = PH_TRAIL;
               end else begin
                  error_nx = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (!is_trail) error_nx = 1'b1;
            end
            default: begin
               error_nx = 1'b1;
            end
         endcase

         if (do_acc) begin
            if (acc_ovf) begin
               error_nx = 1'b1;
            end else begin
               digits_nx = 1'b1;
               case (phase_ff)
                  PH_LAST:  last_acc_nx  = acc_new;
                  PH_TOTAL: total_acc_nx = acc_new;
                  default:  first_acc_nx = acc_new;
               endcase
            end
         end
      end
   end

   always_comb begin
      cap_ok_in = !error_nx && (phase_nx == PH_TOTAL || phase_nx == PH_TRAIL)
                  && (digits_nx || star_nx);
      if (fin_go) begin
         phase_in     = PH_LEAD;
         unit_idx_in  = '0;
         first_acc_in = '0;
         last_acc_in  = '0;
         total_acc_in = '0;
         digits_in    = 1'b0;
         star_in      = 1'b0;
         error_in     = 1'b0;
      end else begin
         phase_in     = phase_nx;
         unit_idx_in  = unit_idx_nx;
         first_acc_in = first_acc_nx;
         last_acc_in  = last_acc_nx;
         total_acc_in = total_acc_nx;
         digits_in    = digits_nx;
         star_in      = star_nx;
         error_in     = error_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         unit_idx_ff  <= '0;
         first_acc_ff <= '0;
         last_acc_ff  <= '0;
         total_acc_ff <= '0;
         digits_ff    <= 1'b0;
         star_ff      <= 1'b0;
         error_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         unit_idx_ff  <= unit_idx_in;
         first_acc_ff <= first_acc_in;
         last_acc_ff  <= last_acc_in;
         total_acc_ff <= total_acc_in;
         digits_ff    <= digits_in;
         star_ff      <= star_in;
         error_ff     <= error_in;
      end
   end

   // capture a finished value
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else if (cap_ready) begin
         cap_valid_ff <= fin_go;
      end
      if (fin_go) begin
         cap_ok_ff    <= cap_ok_in;
         cap_first_ff <= first_acc_nx;
         cap_last_ff  <= last_acc_nx;
         cap_total_ff <= total_acc_nx;
         cap_star_ff  <= star_nx;
      end
   end

   // ---------------------------------------------------------------- compare
   always_comb begin
      last_lt_first = cap_last_ff < cap_first_ff;
      last_ge_total = !cap_star_ff && (cap_last_ff >= cap_total_ff);
      if (!cap_ok_ff) begin
         rsp_status_in = STATUS_MALFORMED;
         rsp_first_in  = '0;
         rsp_last_in   = '0;
         rsp_total_in  = '0;
         rsp_known_in  = 1'b0;
      end else begin
         if (last_lt_first)      rsp_status_in = STATUS_LAST_BEFORE_FIRST;
         else if (last_ge_total) rsp_status_in = STATUS_LAST_NOT_BELOW;
         else                    rsp_status_in = STATUS_OK;
         rsp_first_in = POS_W'(cap_first_ff);
         rsp_last_in  = POS_W'(cap_last_ff);
         rsp_total_in = cap_star_ff ? '0 : POS_W'(cap_total_ff);
         rsp_known_in = !cap_star_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cap_valid_ff;
      end
      if (out_ready && cap_valid_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_first_ff  <= rsp_first_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_total_ff  <= rsp_total_in;
         rsp_known_ff  <= rsp_known_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.first_pos    = rsp_first_ff;
   assign rsp_ch.last_pos     = rsp_last_ff;
   assign rsp_ch.total_length = rsp_total_ff;
   assign rsp_ch.total_known  = rsp_known_ff;

endmodule

[sv/crh_checker.sv]
// ----------------------------------------------------------------------------
// crh_checker
// Port-level checks of the range header parser, bound to the top level.
// ----------------------------------------------------------------------------
module crh_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [crh_pkg::POS_W-1:0]  rsp_first,
   input logic [crh_pkg::POS_W-1:0]  rsp_last,
   input logic [crh_pkg::POS_W-1:0]  rsp_total,
   input logic                       rsp_known
);
   import crh_pkg::*;

   // hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_first) && $stable(rsp_last) && $stable(rsp_total) &&
         $stable(rsp_known))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_malformed_zero: assert property (@(posedge clock)
      rsp_valid && rsp_status == STATUS_MALFORMED |->
         rsp_first == '0 && rsp_last == '0 && rsp_total == '0 && !rsp_known)
      else $error("malformed response carries values");

   a_order: assert property (@(posedge clock)
      rsp_valid && rsp_status != STATUS_MALFORMED |->
         ((rsp_status == STATUS_LAST_BEFORE_FIRST) == (rsp_last < rsp_first)))
      else $error("order status disagrees with positions");

   a_total: assert property (@(posedge clock)
      rsp_valid && rsp_status == STATUS_OK |->
         (rsp_known && rsp_last < rsp_total) || (!rsp_known && rsp_total == '0))
      else $error("ok response disagrees with total");

endmodule

bind content_range_header_parser crh_checker u_crh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_first  (rsp_ch.first_pos),
   .rsp_last   (rsp_ch.last_pos),
   .rsp_total  (rsp_ch.total_length),
   .rsp_known  (rsp_ch.total_known)
);

[dv/content_range_header_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_range_header_parser_tb
// Self-checking bench for the streaming range header parser. Header values
// go in one character per transaction. Each value is parsed again inside the
// bench, character by character, to predict its response. Every response is
// compared field by field against the oldest prediction. A short set of
// hand-written values comes first. Random values follow: mostly well-formed
// ranges with random content, the rest mutated values and loose noise.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module content_range_header_parser_tb;
   import crh_pkg::*;

   localparam logic [63:0] POS_MAX     = (64'd1 << VALUE_BITS) - 64'd1;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          RANDOM_CHARS = 1150;

   typedef struct {
      status_type       status;
      logic [POS_W-1:0] first_pos;
      logic [POS_W-1:0] last_pos;
      logic [POS_W-1:0] total_length;
      logic             total_known;
   } range_result_type;

   class range_scoreboard;
      phase_type        phase;
      int unsigned      unit_idx;
      logic [63:0]      first_acc;
      logic [63:0]      last_acc;
      logic [63:0]      total_acc;
      bit               digits_seen;
      bit               star_seen;
      bit               trail_seen;
      bit               bad;
      range_result_type expected_ranges[$];
      int               errors;

      function new();
         clear_parse();
         errors = 0;
      endfunction

      function void clear_parse();
         phase       = PH_LEAD;
         unit_idx    = 0;
         first_acc   = '0;
         last_acc    = '0;
         total_acc   = '0;
         digits_seen = 1'b0;
         star_seen   = 1'b0;
         trail_seen  = 1'b0;
         bad         = 1'b0;
      endfunction

      function void take_digit(inout logic [63:0] acc, input logic [7:0] d);
         logic [63:0] lim;
         lim = (POS_MAX - 64'(d)) / 64'd10;
         if (acc > lim) begin
            bad = 1'b1;
         end else begin
            acc         = acc * 64'd10 + 64'(d);
            digits_seen = 1'b1;
         end
      endfunction

      function void match_unit_char(logic [7:0] c);
         string      word;
         logic [7:0] lc;
         word = "bytes";
         lc   = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
         if (unit_idx >= 5 || lc != 8'(word[unit_idx])) begin
            bad = 1'b1;
         end else begin
            unit_idx++;
            phase = (unit_idx == 5) ? PH_SEP : PH_UNIT;
         end
      endfunction

      function void parse_char(logic [7:0] c);
         bit         dig;
         bit         blank;
         bit         trail;
         logic [7:0] d;
         dig   = (c >= CH_ZERO && c <= CH_NINE);
         d     = dig ? c - CH_ZERO : 8'd0;
         blank = (c == CH_SPACE || c == CH_TAB);
         trail = blank || c == CH_CR || c == CH_LF;
         case (phase)
            PH_LEAD: begin
               if (!blank) match_unit_char(c);
            end
            PH_UNIT: begin
               match_unit_char(c);
            end
            PH_SEP: begin
               if (blank) phase = PH_GAP;
               else bad = 1'b1;
            end
            PH_GAP: begin
               if (dig) begin
                  phase = PH_FIRST;
                  take_digit(first_acc, d);
               end else if (!blank) begin
                  bad = 1'b1;
               end
            end
            PH_FIRST: begin
               if (dig) begin
                  take_digit(first_acc, d);
               end else if (c == CH_DASH && digits_seen) begin
                  phase       = PH_LAST;
                  digits_seen = 1'b0;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_LAST: begin
               if (dig) begin
                  take_digit(last_acc, d);
               end else if (c == CH_SLASH && digits_seen) begin
                  phase       = PH_TOTAL;
                  digits_seen = 1'b0;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_TOTAL: begin
               if (dig && !star_seen) begin
                  take_digit(total_acc, d);
               end else if (c == CH_STAR && !digits_seen && !star_seen) begin
                  star_seen = 1'b1;
               end else if (trail && (digits_seen || star_seen)) begin
                  phase      = PH_TRAIL;
                  trail_seen = 1'b1;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (!trail) bad = 1'b1;
            end
            default: begin
               bad = 1'b1;
            end
         endcase
      endfunction

      function void note_char(logic [7:0] c, logic fin);
         range_result_type r;
         if (!bad) parse_char(c);
         if (!fin) return;
         if (bad || !(phase == PH_TOTAL || phase == PH_TRAIL) || !(digits_seen || star_seen))
         begin
            r.status       = STATUS_MALFORMED;
            r.first_pos    = '0;
            r.last_pos     = '0;
            r.total_length = '0;
            r.total_known  = 1'b0;
         end else begin
            if (last_acc < first_acc) r.status = STATUS_LAST_BEFORE_FIRST;
            else if (!star_seen && last_acc >= total_acc) r.status = STATUS_LAST_NOT_BELOW;
            else r.status = STATUS_OK;
            r.first_pos    = first_acc[POS_W-1:0];
            r.last_pos     = last_acc[POS_W-1:0];
            r.total_length = star_seen ? '0 : total_acc[POS_W-1:0];
            r.total_known  = !star_seen;
         end
         expected_ranges.push_back(r);
         clear_parse();
      endfunction

      function void flag(string what, logic [63:0] want, logic [63:0] got);
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         errors++;
      endfunction

      function void check_response(input status_type st, input logic [POS_W-1:0] fp,
                                   input logic [POS_W-1:0] lp, input logic [POS_W-1:0] tl,
                                   input logic tk);
         range_result_type r;
         if (expected_ranges.size() == 0) begin
            $display("%0t: response with none expected, status %0d", $time, st);
            errors++;
            return;
         end
         r = expected_ranges.pop_front();
         if (st != r.status) flag("status", 64'(r.status), 64'(st));
         if (fp != r.first_pos) flag("first_pos", 64'(r.first_pos), 64'(fp));
         if (lp != r.last_pos) flag("last_pos", 64'(r.last_pos), 64'(lp));
         if (tl != r.total_length) flag("total_length", 64'(r.total_length), 64'(tl));
         if (tk != r.total_known) flag("total_known", 64'(r.total_known), 64'(tk));
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   chars_sent;

   logic [7:0]      hdr[$];
   range_scoreboard sb;

   crh_req_if req_ch ();
   crh_rsp_if rsp_ch ();

   content_range_header_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_char(req_ch.data_byte, req_ch.final_byte);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_response(rsp_ch.status, rsp_ch.first_pos, rsp_ch.last_pos,
                           rsp_ch.total_length, rsp_ch.total_known);
      end
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("content_range_header_parser: mismatch");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [7:0] pick_char();
      string letters;
      letters = "bytesBYTES";
      case ($urandom_range(0, 9))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return $urandom_range(0, 1) ? CH_CR : CH_LF;
         3: return CH_DASH;
         4: return CH_SLASH;
         5: return CH_STAR;
         6: return CH_ZERO + 8'($urandom_range(0, 9));
         7: return 8'(letters[$urandom_range(0, 9)]);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [63:0] pick_pos();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 64'($urandom_range(0, 999));
         5, 6: return 64'($urandom);
         7: return {$urandom, $urandom} & POS_MAX;
         8: return POS_MAX - 64'($urandom_range(0, 20));
         default: return POS_MAX + 64'($urandom_range(1, 20));
      endcase
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) hdr.push_back(8'(s[i]));
   endtask

   task automatic add_number(input logic [63:0] v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 4) == 0) s = {"0", s};
      add_text(s);
   endtask

   task automatic add_blanks(input int lo, input int hi);
      repeat ($urandom_range(lo, hi)) hdr.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   task automatic send_header(input bit calm);
      int gap;
      for (int i = 0; i < hdr.size(); i++) begin
         req_ch.valid      <= 1'b1;
         req_ch.data_byte  <= hdr[i];
         req_ch.final_byte <= (i == hdr.size() - 1);
         do @(posedge clock); while (!req_ch.ready);
         chars_sent++;
         gap = calm ? 0 : pick_gap();
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_text(input string s);
      hdr.delete();
      add_text(s);
      send_header($urandom_range(0, 1));
   endtask

   task automatic make_range();
      string       word;
      logic [63:0] first;
      logic [63:0] last;
      int          r;
      word = "bytes";
      hdr.delete();
      add_blanks(0, 2);
      for (int i = 0; i < 5; i++) begin
         hdr.push_back($urandom_range(0, 1) ? 8'(word[i]) - CASE_GAP : 8'(word[i]));
      end
      add_blanks(1, 3);
      first = pick_pos();
      r     = $urandom_range(0, 99);
      if (r < 70) last = first + 64'($urandom_range(0, 1000));
      else if (r < 85) last = pick_pos();
      else last = first - 64'($urandom_range(0, 5));
      add_number(first);
      hdr.push_back(CH_DASH);
      add_number(last);
      hdr.push_back(CH_SLASH);
      r = $urandom_range(0, 99);
      if (r < 20) hdr.push_back(CH_STAR);
      else if (r < 70) add_number(last + 64'($urandom_range(1, 1000)));
      else if (r < 85) add_number(last - 64'($urandom_range(0, 2)));
      else add_number(pick_pos());
      repeat ($urandom_range(0, 2)) begin
         hdr.push_back($urandom_range(0, 1) ? ($urandom_range(0, 1) ? CH_CR : CH_LF)
                                            : ($urandom_range(0, 1) ? CH_SPACE : CH_TAB));
      end
   endtask

   task automatic break_range();
      int idx;
      idx = $urandom_range(0, hdr.size() - 1);
      case ($urandom_range(0, 2))
         0: hdr[idx] = pick_char();
         1: hdr.delete(idx);
         default: hdr.insert(idx, pick_char());
      endcase
   endtask

   initial begin
      int r;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         rsp_ch.ready <= 1'b1;
         r = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
         repeat (r) @(posedge clock);
         r = pick_gap();
         if (r > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (r) @(posedge clock);
         end
      end
   end

   initial begin
      int    rand_start;
      string cases[$];
      sb                = new();
      chars_sent        = 0;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.data_byte  <= '0;
      req_ch.final_byte <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      cases = '{
         "bytes 0-0/1",
         " \t BYTES\t\t0-499/1234",
         "ByTeS 7-7/8",
         "bytes 5-3/10",
         "bytes 0-10/10",
         "bytes 0-9/*",
         "bytes 0-9223372036854775807/*",
         "bytes 1-2/9223372036854775807",
         "bytes 9223372036854775808-9/10",
         "bytes 1-2/18446744073709551616",
         "bytes -1/2",
         "bytes 1-/2",
         "bytes 1-2/",
         "bytes 1-2",
         "by tes 1-2/3",
         "bytes 1 2-3/4",
         "bytes1-2/3",
         "bytes 1-2/*5",
         "bytes 1-2/5*",
         "bytes 1-2/**",
         "bytes 1-2/3 \t x",
         "bytesx 1-2/3",
         "x",
         " "
      };
      foreach (cases[i]) send_text(cases[i]);

      // trailing CR LF after a star total, CR inside the value, extreme codes
      hdr.delete();
      add_text("bytes 0-9/* ");
      hdr.push_back(CH_CR);
      hdr.push_back(CH_LF);
      send_header(1'b0);
      hdr.delete();
      add_text("bytes");
      hdr.push_back(CH_CR);
      add_text(" 1-2/3");
      send_header(1'b1);
      hdr.delete();
      hdr.push_back(8'h00);
      hdr.push_back(8'hFF);
      send_header(1'b0);

      rand_start = chars_sent;
      while (chars_sent - rand_start < RANDOM_CHARS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
               make_range();
            end
            14, 15, 16: begin
               make_range();
               repeat ($urandom_range(1, 2)) break_range();
            end
            default: begin
               hdr.delete();
               repeat ($urandom_range(1, 6)) begin
                  hdr.push_back($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
               end
            end
         endcase
         send_header($urandom_range(0, 3) == 0);
      end
      req_ch.valid <= 1'b0;

      while (sb.expected_ranges.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.expected_ranges.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, sb.expected_ranges.size());
      end
      if (sb.errors == 0 && sb.expected_ranges.size() == 0) begin
         $display("content_range_header_parser: match");
      end else begin
         $display("content_range_header_parser: mismatch");
      end
      $finish;
   end

endmodule
